FILE: sv/usm_pkg.sv
`timescale 1ns / 1ps
// usm_pkg: widths, constants, register codes and helpers of the UV sphere point block.
// No dependencies.
package usm_pkg;

  localparam int MAX_DIVISIONS = 256;
  localparam int CNT_W         = 9;
  localparam int RAD_W         = 16;
  localparam int IDX_W         = 9;
  localparam int POS_W         = 17;
  localparam int VTX_W         = 17;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_COUNT = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;
  localparam logic [CNT_W-1:0] COUNT_RESET  = 9'd16;

  // angle path
  localparam int NUM_W        = 42;
  localparam int QUO_W        = 36;
  localparam int DIV_BPS      = 4;
  localparam int DIV_STAGES   = QUO_W / DIV_BPS;
  localparam int REM_W        = 8;
  localparam int ANG_W        = 34;
  localparam int TRIG_W       = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_PER   = 3;
  localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER;
  localparam int SCALE_STAGES = 4;
  localparam int LATENCY      = 1 + DIV_STAGES + CORDIC_STAGES + 2 + SCALE_STAGES;

  localparam logic [QUO_W-1:0] PI_Q30            = 36'd3373259426;
  localparam logic [QUO_W-1:0] HALF_PI_Q30       = 36'd1686629713;
  localparam logic [QUO_W-1:0] THREE_HALF_PI_Q30 = 36'd5059889139;
  localparam logic [QUO_W-1:0] TWO_PI_Q30        = 36'd6746518852;
  localparam logic signed [ANG_W-1:0] CORDIC_K   = 34'sd652032874;
  localparam logic signed [POS_W-1:0] POS_LIMIT  = 17'sd65535;

  typedef struct packed {
    logic             inr;
    logic             qv;
    logic [VTX_W-1:0] k1;
    logic [VTX_W-1:0] k2;
  } usm_side_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int k);
    logic signed [ANG_W-1:0] a;
    unique case (k)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      default: a = (k < CORDIC_STEPS) ? (34'sd1 <<< (30 - k)) : 34'sd0;
    endcase
    return a;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = v[CNT_W-1:0];
    if (c == '0) c = CNT_W'(1);
    else if (c > CNT_W'(MAX_DIVISIONS)) c = CNT_W'(MAX_DIVISIONS);
    return c;
  endfunction

endpackage

FILE: sv/usm_in_if.sv
`timescale 1ns / 1ps
// usm_in_if: grid point channel (valid/ready plus indices).
// Depends on usm_pkg.
interface usm_in_if;
  import usm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] lat_index;
  logic [IDX_W-1:0] long_index;
  modport source (output valid, lat_index, long_index, input ready);
  modport sink (input valid, lat_index, long_index, output ready);
endinterface

FILE: sv/usm_out_if.sv
`timescale 1ns / 1ps
// usm_out_if: result channel (position, quad flag, triangle vertex indices).
// Depends on usm_pkg.
interface usm_out_if;
  import usm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    in_range;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    quad_valid;
  logic [VTX_W-1:0]        tri_a0;
  logic [VTX_W-1:0]        tri_a1;
  logic [VTX_W-1:0]        tri_a2;
  logic [VTX_W-1:0]        tri_b0;
  logic [VTX_W-1:0]        tri_b1;
  logic [VTX_W-1:0]        tri_b2;
  modport source (output valid, in_range, pos_x, pos_y, pos_z, quad_valid,
                  tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, input ready);
  modport sink (input valid, in_range, pos_x, pos_y, pos_z, quad_valid,
                tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, output ready);
endinterface

FILE: sv/usm_div.sv
`timescale 1ns / 1ps
// usm_div: pipelined restoring divider, four quotient bits per stage.
// Depends on usm_pkg. Numerator must satisfy num < den * 2**QUO_W.
module usm_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [usm_pkg::NUM_W-1:0] num,
  input  logic [usm_pkg::CNT_W-1:0] den,
  output logic [usm_pkg::QUO_W-1:0] quo
);
  import usm_pkg::*;

  logic [REM_W-1:0] rem_s [DIV_STAGES+1];
  logic [QUO_W-1:0] num_s [DIV_STAGES+1];
  logic [QUO_W-1:0] quo_s [DIV_STAGES+1];

  assign rem_s[0] = REM_W'(num[NUM_W-1:QUO_W]);
  assign num_s[0] = num[QUO_W-1:0];
  assign quo_s[0] = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [REM_W-1:0] rem_next;
    logic [QUO_W-1:0] num_next;
    logic [QUO_W-1:0] quo_next;

    always_comb begin
      logic [REM_W:0] t;
      rem_next = rem_s[s];
      num_next = num_s[s];
      quo_next = quo_s[s];
      for (int b = 0; b < DIV_BPS; b++) begin
        t        = {rem_next, num_next[QUO_W-1]};
        num_next = {num_next[QUO_W-2:0], 1'b0};
        if (t >= den) begin
          rem_next = REM_W'(t - den);
          quo_next = {quo_next[QUO_W-2:0], 1'b1};
        end else begin
          rem_next = t[REM_W-1:0];
          quo_next = {quo_next[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[s+1] <= rem_next;
        num_s[s+1] <= num_next;
        quo_s[s+1] <= quo_next;
      end
    end
  end

  assign quo = quo_s[DIV_STAGES];

endmodule

FILE: sv/usm_cordic.sv
`timescale 1ns / 1ps
// usm_cordic: quadrant fold, 30-step rotation CORDIC (3 steps per stage), sign fix.
// Depends on usm_pkg. Angle in unsigned Q6.30 radians, 0..2pi; cos/sin out in Q2.30.
module usm_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic [usm_pkg::QUO_W-1:0]         ang,
  output logic signed [usm_pkg::TRIG_W-1:0] cos_v,
  output logic signed [usm_pkg::TRIG_W-1:0] sin_v
);
  import usm_pkg::*;

  logic signed [ANG_W-1:0] x_s [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] y_s [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] z_s [CORDIC_STAGES+1];
  logic                    neg_s [CORDIC_STAGES+1];

  logic signed [QUO_W:0]   ang_ext;
  logic signed [QUO_W:0]   fold;
  logic                    fold_neg;

  assign ang_ext = $signed({1'b0, ang});

  always_comb begin
    fold     = ang_ext;
    fold_neg = 1'b0;
    if (ang > HALF_PI_Q30) begin
      if (ang <= THREE_HALF_PI_Q30) begin
        fold     = ang_ext - $signed({1'b0, PI_Q30});
        fold_neg = 1'b1;
      end else begin
        fold = ang_ext - $signed({1'b0, TWO_PI_Q30});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0]   <= CORDIC_K;
      y_s[0]   <= '0;
      z_s[0]   <= fold[ANG_W-1:0];
      neg_s[0] <= fold_neg;
    end
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [ANG_W-1:0] x_next, y_next, z_next;

    always_comb begin
      logic signed [ANG_W-1:0] dx, dy;
      x_next = x_s[s];
      y_next = y_s[s];
      z_next = z_s[s];
      for (int t = 0; t < CORDIC_PER; t++) begin
        dx = y_next >>> (s * CORDIC_PER + t);
        dy = x_next >>> (s * CORDIC_PER + t);
        if (z_next >= 0) begin
          x_next = x_next - dx;
          y_next = y_next + dy;
          z_next = z_next - atan_q30(s * CORDIC_PER + t);
        end else begin
          x_next = x_next + dx;
          y_next = y_next - dy;
          z_next = z_next + atan_q30(s * CORDIC_PER + t);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_s[s+1]   <= x_next;
        y_s[s+1]   <= y_next;
        z_s[s+1]   <= z_next;
        neg_s[s+1] <= neg_s[s];
      end
    end
  end

  logic signed [ANG_W-1:0] x_fix, y_fix;
  assign x_fix = neg_s[CORDIC_STAGES] ? -x_s[CORDIC_STAGES] : x_s[CORDIC_STAGES];
  assign y_fix = neg_s[CORDIC_STAGES] ? -y_s[CORDIC_STAGES] : y_s[CORDIC_STAGES];

  // magnitudes stay near 2**30, so the top two bits are sign copies
  always_ff @(posedge clk) begin
    if (en) begin
      cos_v <= x_fix[TRIG_W-1:0];
      sin_v <= y_fix[TRIG_W-1:0];
    end
  end

endmodule

FILE: sv/usm_scale.sv
`timescale 1ns / 1ps
// usm_scale: trig products, radius scaling, rounding and saturation to Q8.8.
// Depends on usm_pkg. Four register stages.
module usm_scale (
  input  logic                              clk,
  input  logic                              en,
  input  logic [usm_pkg::RAD_W-1:0]         radius,
  input  logic signed [usm_pkg::TRIG_W-1:0] sin_th,
  input  logic signed [usm_pkg::TRIG_W-1:0] cos_th,
  input  logic signed [usm_pkg::TRIG_W-1:0] cos_ph,
  input  logic signed [usm_pkg::TRIG_W-1:0] sin_ph,
  output logic signed [usm_pkg::POS_W-1:0]  pos_x,
  output logic signed [usm_pkg::POS_W-1:0]  pos_y,
  output logic signed [usm_pkg::POS_W-1:0]  pos_z
);
  import usm_pkg::*;

  localparam int PROD_W = 2 * TRIG_W;
  localparam int F_W    = ANG_W;
  localparam int RP_W   = RAD_W + 1 + F_W;
  localparam int V_W    = RP_W - 30;

  function automatic logic signed [V_W-1:0] sat_pos(input logic signed [V_W-1:0] v);
    logic signed [V_W-1:0] r;
    r = v;
    if (v > V_W'(POS_LIMIT)) r = V_W'(POS_LIMIT);
    else if (v < -V_W'(POS_LIMIT)) r = -V_W'(POS_LIMIT);
    return r;
  endfunction

  logic signed [PROD_W-1:0] px1, py1;
  logic signed [TRIG_W-1:0] cz1, cz2;
  logic signed [F_W-1:0]    fx2, fy2;
  logic signed [RP_W-1:0]   rx3, ry3, rz3;
  logic signed [PROD_W-1:0] px_rnd, py_rnd;
  logic signed [RP_W-1:0]   rx_rnd, ry_rnd, rz_rnd;
  logic signed [RAD_W:0]    rad_s;
  logic signed [V_W-1:0]    vx, vy, vz;

  assign rad_s  = $signed({1'b0, radius});
  assign px_rnd = (px1 + (PROD_W'(1) <<< 29)) >>> 30;
  assign py_rnd = (py1 + (PROD_W'(1) <<< 29)) >>> 30;
  assign rx_rnd = (rx3 + (RP_W'(1) <<< 29)) >>> 30;
  assign ry_rnd = (ry3 + (RP_W'(1) <<< 29)) >>> 30;
  assign rz_rnd = (rz3 + (RP_W'(1) <<< 29)) >>> 30;
  assign vx = sat_pos(rx_rnd[V_W-1:0]);
  assign vy = sat_pos(ry_rnd[V_W-1:0]);
  assign vz = sat_pos(rz_rnd[V_W-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      px1   <= sin_th * cos_ph;
      py1   <= sin_th * sin_ph;
      cz1   <= cos_th;
      fx2   <= px_rnd[F_W-1:0];
      fy2   <= py_rnd[F_W-1:0];
      cz2   <= cz1;
      rx3   <= rad_s * fx2;
      ry3   <= rad_s * fy2;
      rz3   <= rad_s * cz2;
      pos_x <= vx[POS_W-1:0];
      pos_y <= vy[POS_W-1:0];
      pos_z <= vz[POS_W-1:0];
    end
  end

endmodule

FILE: sv/uv_sphere_mesh_point.sv
`timescale 1ns / 1ps
// UV sphere grid point: one point per cycle in, one result per cycle out unless the
// result beat is held. Depth is set by the two 36-bit angle dividers
// (4 quotient bits per stage, 9 stages) and the two 30-step CORDICs (3 steps per
// stage, plus fold and sign stages), then 4 stages of scaling. The pipeline stalls
// as a whole only when the result beat is held. Configure only while idle.
// Depends on usm_pkg, usm_in_if, usm_out_if, usm_div, usm_cordic, usm_scale.
module uv_sphere_mesh_point (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [usm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [usm_pkg::CFG_DATA_W-1:0] cfg_data,
  usm_in_if.sink                         pt_in,
  usm_out_if.source                      pt_out
);
  import usm_pkg::*;

  logic [RAD_W-1:0] radius;
  logic [CNT_W-1:0] lat_count;
  logic [CNT_W-1:0] long_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= RADIUS_RESET;
      lat_count  <= COUNT_RESET;
      long_count <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:     radius     <= cfg_data[RAD_W-1:0];
        REG_LAT_COUNT:  lat_count  <= clamp_count(cfg_data);
        REG_LONG_COUNT: long_count <= clamp_count(cfg_data);
        default: ;
      endcase
    end
  end

  logic               adv;
  logic [LATENCY-1:0] vld;
  usm_side_t          side [LATENCY];
  usm_side_t          side_in;
  logic [IDX_W-1:0]   i_in, j_in;
  logic [NUM_W-1:0]   num_th, num_ph;

  assign adv         = ~vld[LATENCY-1] | pt_out.ready;
  assign pt_in.ready = adv;

  always_comb begin
    side_in.inr = (pt_in.lat_index <= lat_count) && (pt_in.long_index <= long_count);
    side_in.qv  = (pt_in.lat_index < lat_count) && (pt_in.long_index < long_count);
    i_in = side_in.inr ? pt_in.lat_index : '0;
    j_in = side_in.inr ? pt_in.long_index : '0;
    side_in.k1 = VTX_W'(i_in) * (VTX_W'(long_count) + VTX_W'(1)) + VTX_W'(j_in);
    side_in.k2 = side_in.k1 + VTX_W'(long_count) + VTX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LATENCY-2:0], pt_in.valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
      for (int k = 1; k < LATENCY; k++) side[k] <= side[k-1];
      num_th <= NUM_W'(i_in) * NUM_W'(PI_Q30) + NUM_W'(lat_count >> 1);
      num_ph <= NUM_W'(j_in) * NUM_W'(TWO_PI_Q30) + NUM_W'(long_count >> 1);
    end
  end

  logic [QUO_W-1:0]         q_th, q_ph;
  logic signed [TRIG_W-1:0] ct, st, cp, sp;
  logic signed [POS_W-1:0]  px, py, pz;

  usm_div u_div_th (.clk, .en(adv), .num(num_th), .den(lat_count), .quo(q_th));
  usm_div u_div_ph (.clk, .en(adv), .num(num_ph), .den(long_count), .quo(q_ph));

  usm_cordic u_cor_th (.clk, .en(adv), .ang(q_th), .cos_v(ct), .sin_v(st));
  usm_cordic u_cor_ph (.clk, .en(adv), .ang(q_ph), .cos_v(cp), .sin_v(sp));

  usm_scale u_scale (
    .clk, .en(adv), .radius,
    .sin_th(st), .cos_th(ct), .cos_ph(cp), .sin_ph(sp),
    .pos_x(px), .pos_y(py), .pos_z(pz)
  );

  usm_side_t so;
  assign so = side[LATENCY-1];

  assign pt_out.valid      = vld[LATENCY-1];
  assign pt_out.in_range   = so.inr;
  assign pt_out.pos_x      = so.inr ? px : '0;
  assign pt_out.pos_y      = so.inr ? py : '0;
  assign pt_out.pos_z      = so.inr ? pz : '0;
  assign pt_out.quad_valid = so.qv;
  assign pt_out.tri_a0     = so.qv ? so.k1 : '0;
  assign pt_out.tri_a1     = so.qv ? so.k2 : '0;
  assign pt_out.tri_a2     = so.qv ? so.k1 + VTX_W'(1) : '0;
  assign pt_out.tri_b0     = so.qv ? so.k1 + VTX_W'(1) : '0;
  assign pt_out.tri_b1     = so.qv ? so.k2 : '0;
  assign pt_out.tri_b2     = so.qv ? so.k2 + VTX_W'(1) : '0;

  a_quad_in_range: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && pt_out.quad_valid |-> pt_out.in_range)
    else $error("quad flagged outside the grid");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && pt_out.quad_valid |->
      pt_out.tri_a1 == pt_out.tri_a0 + VTX_W'(long_count) + VTX_W'(1))
    else $error("k2 does not follow k1 by one row");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && !pt_out.ready |-> !pt_in.ready)
    else $error("input taken while result beat is held");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    lat_count != '0 && long_count != '0 &&
    lat_count <= CNT_W'(MAX_DIVISIONS) && long_count <= CNT_W'(MAX_DIVISIONS))
    else $error("division count out of range");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: checks uv_sphere_mesh_point against a CORDIC-based position and quad predictor
// under random bursts on the point channel and random stalls on the result channel.
// Depends on usm_pkg, usm_in_if, usm_out_if and the block's RTL.
module testbench;
  import usm_pkg::*;

  typedef struct {
    logic                    in_range;
    logic signed [POS_W-1:0] px, py, pz;
    logic                    quad_valid;
    logic [VTX_W-1:0]        a0, a1, a2, b0, b1, b2;
  } point_t;

  localparam longint ATAN_TAB [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint LIMIT = 1000000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  usm_in_if pt_in ();
  usm_out_if pt_out ();

  uv_sphere_mesh_point DUT (.clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
                            .cfg_data(cfg_data), .pt_in(pt_in), .pt_out(pt_out));

  always #4 clk = ~clk;

  longint sph_radius, sph_lat, sph_long;
  point_t expected_points[$];
  int mismatches = 0;
  longint cycles = 0;
  int burst_left = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round30(longint p);
    return floor_shift(p + (64'sd1 << 29), 30);
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit neg;
    x = 652032874; y = 0; neg = 0;
    if (ang > 64'sd1686629713) begin
      if (ang <= 64'sd5059889139) begin
        ang -= 64'sd3373259426; neg = 1;
      end else ang -= 64'sd6746518852;
    end
    z = ang;
    for (int k = 0; k < 30; k++) begin
      dx = floor_shift(y, k); dy = floor_shift(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[k];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[k];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic signed [POS_W-1:0] scale_to_radius(longint f);
    longint v;
    v = round30(sph_radius * f);
    if (v > 65535) v = 65535;
    if (v < -65535) v = -65535;
    return POS_W'(v);
  endfunction

  function automatic point_t predict_point(longint i, longint j);
    point_t p;
    longint th, ph, ct, st, cp, sp, k1, k2;
    p = '{default: '0};
    if (i > sph_lat || j > sph_long) return p;
    th = (i * 64'sd3373259426 + sph_lat / 2) / sph_lat;
    ph = (j * 64'sd6746518852 + sph_long / 2) / sph_long;
    sin_cos(th, ct, st);
    sin_cos(ph, cp, sp);
    p.in_range = 1;
    p.px = scale_to_radius(round30(st * cp));
    p.py = scale_to_radius(round30(st * sp));
    p.pz = scale_to_radius(ct);
    if (i < sph_lat && j < sph_long) begin
      k1 = i * (sph_long + 1) + j;
      k2 = k1 + sph_long + 1;
      p.quad_valid = 1;
      p.a0 = VTX_W'(k1); p.a1 = VTX_W'(k2); p.a2 = VTX_W'(k1 + 1);
      p.b0 = VTX_W'(k1 + 1); p.b1 = VTX_W'(k2); p.b2 = VTX_W'(k2 + 1);
    end
    return p;
  endfunction

  function automatic longint clamp_div(longint v);
    v = v & 'h1FF;
    if (v < 1) v = 1;
    if (v > MAX_DIVISIONS) v = MAX_DIVISIONS;
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_RADIUS:     sph_radius = val;
      REG_LAT_COUNT:  sph_lat = clamp_div(val);
      REG_LONG_COUNT: sph_long = clamp_div(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    pt_in.valid <= 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_point(logic [IDX_W-1:0] i, logic [IDX_W-1:0] j);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pt_in.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    pt_in.valid <= 1; pt_in.lat_index <= i; pt_in.long_index <= j;
    @(posedge clk);
    while (!pt_in.ready) @(posedge clk);
    expected_points.push_back(predict_point(i, j));
  endtask

  task automatic configure(logic [15:0] r, logic [15:0] la, logic [15:0] lo);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_LAT_COUNT, la);
    write_reg(REG_LONG_COUNT, lo);
  endtask

  task automatic test_directed();
    send_point(0, 0);
    send_point(16, 16);
    send_point(8, 4);
    send_point(17, 0);
    send_point(0, 17);
    send_point(511, 511);
    send_point(16, 3);
    send_point(3, 16);
    configure(16'hFFFF, 256, 256);
    send_point(128, 0); send_point(255, 255); send_point(256, 256);
    send_point(64, 32); send_point(257, 0); send_point(0, 300);
    configure(0, 0, 16'h1FF);
    send_point(0, 0); send_point(1, 1); send_point(1, 128); send_point(2, 0);
    configure(1, 3, 16'h0200);
    send_point(1, 0); send_point(3, 1); send_point(2, 2);
  endtask

  task automatic test_random(int n);
    int lat_max, long_max;
    for (int k = 0; k < n; k++) begin
      if (k % 200 == 0)
        configure($urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(1, 65535),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 40),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 40));
      lat_max = int'(sph_lat); long_max = int'(sph_long);
      if ($urandom_range(0, 9) == 0) send_point(IDX_W'($urandom), IDX_W'($urandom));
      else send_point(IDX_W'($urandom_range(0, lat_max)), IDX_W'($urandom_range(0, long_max)));
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) pt_out.ready <= 0;
    else pt_out.ready <= ($urandom_range(0, 7) != 0) || (cycles[9:8] == 2'b01);
  end

  always @(posedge clk) begin
    point_t e;
    if (!rst && pt_out.valid && pt_out.ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = expected_points.pop_front();
        if (pt_out.in_range !== e.in_range || pt_out.pos_x !== e.px
            || pt_out.pos_y !== e.py || pt_out.pos_z !== e.pz
            || pt_out.quad_valid !== e.quad_valid || pt_out.tri_a0 !== e.a0
            || pt_out.tri_a1 !== e.a1 || pt_out.tri_a2 !== e.a2 || pt_out.tri_b0 !== e.b0
            || pt_out.tri_b1 !== e.b1 || pt_out.tri_b2 !== e.b2) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %b %0d %0d %0d %b %0d %0d %0d %0d %0d %0d",
                     e.in_range, e.px, e.py, e.pz, e.quad_valid, e.a0, e.a1, e.a2,
                     e.b0, e.b1, e.b2,
                     " got %b %0d %0d %0d %b %0d %0d %0d %0d %0d %0d",
                     pt_out.in_range, pt_out.pos_x, pt_out.pos_y,
                     pt_out.pos_z, pt_out.quad_valid, pt_out.tri_a0, pt_out.tri_a1,
                     pt_out.tri_a2, pt_out.tri_b0, pt_out.tri_b1, pt_out.tri_b2);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    pt_in.valid = 0; pt_in.lat_index = '0; pt_in.long_index = '0;
    sph_radius = RADIUS_RESET; sph_lat = COUNT_RESET; sph_long = COUNT_RESET;
    repeat (9) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random(1400);
    drain();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
